// ----- sv/hcbd_pkg.sv -----
// Package for the chunked body decoder: transfer payload types, parser phases,
// character constants and small character-class helpers.
// No dependencies.
package hcbd_pkg;

   // One body byte in, at most one decoded result out
   typedef struct packed {
      logic [7:0] body_byte;
      logic       body_start;
   } req_payload_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       chunk_last;
   } rsp_payload_type;

   // Result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Parser phases; the size-line phases come first so they compare below PH_DATA
   typedef enum logic [3:0] {
      PH_WS     = 4'd0,
      PH_ZERO   = 4'd1,
      PH_X      = 4'd2,
      PH_DIGITS = 4'd3,
      PH_REST   = 4'd4,
      PH_DATA   = 4'd5,
      PH_TRAIL1 = 4'd6,
      PH_TRAIL2 = 4'd7,
      PH_DONE   = 4'd8
   } phase_type;

   // Characters of interest
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;

   // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [7:0] diff;
      begin
         diff = 8'd0;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff = c - CHAR_ZERO;
            hex_decode = {1'b1, diff[3:0]};
         end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
            diff = c - CHAR_LO_A + 8'd10;
            hex_decode = {1'b1, diff[3:0]};
         end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            diff = c - CHAR_UP_A + 8'd10;
            hex_decode = {1'b1, diff[3:0]};
         end else begin
            hex_decode = {1'b0, diff[3:0]};
         end
      end
   endfunction

   // Space, TAB, LF, VT, FF, CR
   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

endpackage

// ----- sv/http_chunked_body_decoder.sv -----
// Chunked transfer-coding body decoder: parser state and result register.
// Depends on hcbd_pkg.
//
// Usage:
//   req_* carries one raw body byte per transfer; body_start marks the first
//   byte of a new body and restarts the parser before that byte is used.
//   rsp_* carries at most one result per input byte: a decoded data byte
//   (kind data, chunk_last on the final byte of each chunk) or a single end
//   result when a zero-size chunk line completes. Size lines, the two bytes
//   after each chunk and everything after the end produce no transfer.
// Timing:
//   The parser state is updated at the input transfer and the result is held
//   in one output register, so a result appears in the cycle after its byte.
//   One byte per cycle is sustained while rsp_ready stays high; the single
//   state update per byte sets that figure.
// Reset and stall:
//   Synchronous reset returns the parser to the start of a size line and
//   empties the output register. While a result waits unaccepted, req_ready
//   is low; it rises in the same cycle rsp_ready frees the register.
module http_chunked_body_decoder
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   phase_type              phase_ff, phase_in;
   logic [SIZE_BITS-1:0]   acc_ff, acc_in;
   logic [SIZE_BITS-1:0]   left_ff, left_in;
   logic                   saw_cr_ff, saw_cr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   req_xfer;
   logic                   has_result;
   rsp_payload_type        result;

   // Byte taken whenever the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Parser state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WS;
         acc_ff    <= '0;
         left_ff   <= '0;
         saw_cr_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         left_ff   <= left_in;
         saw_cr_ff <= saw_cr_in;
      end
   end

   // Next parser state and result for the offered byte
   always_comb begin
      phase_type            ph;
      phase_type            ph_line;
      logic [SIZE_BITS-1:0] acc;
      logic [SIZE_BITS-1:0] left;
      logic [SIZE_BITS-1:0] left_dec;
      logic                 cr;
      logic [7:0]           c;
      logic [4:0]           hex;
      logic [SIZE_BITS-1:0] acc_digit;

      c   = req_data.body_byte;
      hex = hex_decode(c);

      // A new body restarts everything before the byte is used
      ph   = req_data.body_start ? PH_WS : phase_ff;
      acc  = req_data.body_start ? '0 : acc_ff;
      left = req_data.body_start ? '0 : left_ff;
      cr   = req_data.body_start ? 1'b0 : saw_cr_ff;

      // Saturating acc*16 + digit: overflow exactly when the top nibble is set
      acc_digit = (|acc[SIZE_BITS-1 -: 4]) ? '1 : {acc[SIZE_BITS-5:0], hex[3:0]};
      left_dec  = left - {{(SIZE_BITS-1){1'b0}}, 1'b1};

      ph_line    = ph;
      phase_in   = ph;
      acc_in     = acc;
      left_in    = left;
      saw_cr_in  = cr;
      has_result = 1'b0;
      result     = '{kind: KIND_DATA, data_byte: 8'd0, chunk_last: 1'b0};

      unique case (ph)
         PH_WS, PH_ZERO, PH_X, PH_DIGITS, PH_REST: begin
            saw_cr_in = 1'b0;
            if (cr && c == CHAR_LF) begin
               // Line complete
               if (acc == '0) begin
                  phase_in   = PH_DONE;
                  has_result = 1'b1;
                  result     = '{kind: KIND_END, data_byte: 8'd0, chunk_last: 1'b0};
               end else begin
                  left_in  = acc;
                  phase_in = PH_DATA;
               end
            end else begin
               // A held CR not followed by LF counts as a blank line character
               if (cr && (ph == PH_ZERO || ph == PH_X || ph == PH_DIGITS)) begin
                  ph_line = PH_REST;
               end
               phase_in = ph_line;
               if (c == CHAR_CR) begin
                  saw_cr_in = 1'b1;
               end else begin
                  unique case (ph_line)
                     PH_WS: begin
                        if (is_blank(c)) begin
                           phase_in = PH_WS;
                        end else if (c == CHAR_ZERO) begin
                           phase_in = PH_ZERO;
                        end else if (hex[4]) begin
                           acc_in   = acc_digit;
                           phase_in = PH_DIGITS;
                        end else begin
                           phase_in = PH_REST;
                        end
                     end
                     PH_ZERO: begin
                        if (c == CHAR_LO_X || c == CHAR_UP_X) begin
                           phase_in = PH_X;
                        end else if (hex[4]) begin
                           acc_in   = acc_digit;
                           phase_in = PH_DIGITS;
                        end else begin
                           phase_in = PH_REST;
                        end
                     end
                     PH_X, PH_DIGITS: begin
                        if (hex[4]) begin
                           acc_in   = acc_digit;
                           phase_in = PH_DIGITS;
                        end else begin
                           phase_in = PH_REST;
                        end
                     end
                     default: begin
                        phase_in = ph_line;
                     end
                  endcase
               end
            end
         end
         PH_DATA: begin
            left_in    = left_dec;
            has_result = 1'b1;
            result     = '{kind: KIND_DATA, data_byte: c, chunk_last: (left_dec == '0)};
            if (left_dec == '0) begin
               phase_in = PH_TRAIL1;
            end
         end
         PH_TRAIL1: begin
            phase_in = PH_TRAIL2;
         end
         PH_TRAIL2: begin
            phase_in  = PH_WS;
            acc_in    = '0;
            saw_cr_in = 1'b0;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      // Hold state unless a byte is transferred
      if (!req_xfer) begin
         phase_in  = phase_ff;
         acc_in    = acc_ff;
         left_in   = left_ff;
         saw_cr_in = saw_cr_ff;
      end
   end

   // Output register control
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (req_xfer) begin
         rsp_valid_in = has_result;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- tb/http_chunked_body_decoder_tb.sv -----
// Self-checking testbench for the chunked body decoder: drives body bytes over
// req_*, predicts decoded bytes and end results, checks rsp_* in order.
// Depends on hcbd_pkg and http_chunked_body_decoder.
`timescale 1ns / 100ps

module http_chunked_body_decoder_tb;
   import hcbd_pkg::*;

   localparam int SIZE_BITS = 32;
   localparam logic [63:0] SIZE_MAX = {64{1'b1}} >> (64 - SIZE_BITS);
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int HOLD_OFF_CYCLES = 300;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   // Shadow parser state
   phase_type   parse_phase = PH_WS;
   logic [63:0] size_acc = '0;
   logic [63:0] left_count = '0;
   bit          cr_pending = 1'b0;

   // Decoded results still owed by the block, oldest first
   rsp_payload_type decoded_due[$];

   bit mark_start = 1'b0;
   bit offering = 1'b0;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;
   int hold_off_request = 0;
   int items_sent = 0;
   int fail_count = 0;
   int idle_cycles = 0;

   http_chunked_body_decoder #(
      .SIZE_BITS (SIZE_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int digit_value(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_LO_A && c <= CHAR_LO_F) return int'(c - CHAR_LO_A) + 10;
      if (c >= CHAR_UP_A && c <= CHAR_UP_F) return int'(c - CHAR_UP_A) + 10;
      return -1;
   endfunction

   // A hex digit extends the size (saturating), anything else ends the number
   function automatic void take_digit(input int d);
      if (d < 0) begin
         parse_phase = PH_REST;
      end else begin
         if (size_acc > (SIZE_MAX - 64'(d)) / 16) size_acc = SIZE_MAX;
         else size_acc = size_acc * 16 + 64'(d);
         parse_phase = PH_DIGITS;
      end
   endfunction

   function automatic void restart_line();
      parse_phase = PH_WS;
      size_acc = '0;
      cr_pending = 1'b0;
   endfunction

   // One ordinary size-line character
   function automatic void size_line_char(input logic [7:0] c);
      int d;
      d = digit_value(c);
      case (parse_phase)
         PH_WS: begin
            if (!(c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) begin
               if (c == CHAR_ZERO) parse_phase = PH_ZERO;
               else take_digit(d);
            end
         end
         PH_ZERO: begin
            if (c == CHAR_LO_X || c == CHAR_UP_X) parse_phase = PH_X;
            else take_digit(d);
         end
         PH_X, PH_DIGITS: take_digit(d);
         default: ;
      endcase
   endfunction

   // Advance the shadow parser by one accepted byte and queue any result
   function automatic void decode_body_byte(input logic [7:0] c, input bit start);
      if (start) begin
         restart_line();
         left_count = '0;
      end
      if (parse_phase <= PH_REST) begin
         if (cr_pending) begin
            cr_pending = 1'b0;
            if (c == CHAR_LF) begin
               if (size_acc == 0) begin
                  parse_phase = PH_DONE;
                  decoded_due.push_back('{kind: KIND_END, data_byte: 8'h00,
                                          chunk_last: 1'b0});
               end else begin
                  left_count = size_acc;
                  parse_phase = PH_DATA;
               end
               return;
            end
            // CR without LF counts as a plain line character
            size_line_char(CHAR_CR);
         end
         if (c == CHAR_CR) cr_pending = 1'b1;
         else size_line_char(c);
      end else begin
         case (parse_phase)
            PH_DATA: begin
               left_count = (left_count - 1) & SIZE_MAX;
               decoded_due.push_back('{kind: KIND_DATA, data_byte: c,
                                       chunk_last: left_count == 0});
               if (left_count == 0) parse_phase = PH_TRAIL1;
            end
            PH_TRAIL1: parse_phase = PH_TRAIL2;
            PH_TRAIL2: restart_line();
            default: ;
         endcase
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_decoded
      rsp_payload_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d data %02h last %0d",
                     $time, rsp_data.kind, rsp_data.data_byte, rsp_data.chunk_last);
            fail_count++;
         end else begin
            due = decoded_due.pop_front();
            check_field("kind", due.kind, rsp_data.kind);
            check_field("data_byte", due.data_byte, rsp_data.data_byte);
            check_field("chunk_last", due.chunk_last, rsp_data.chunk_last);
         end
      end
   end

   // Watchdog: too long without any transfer means the block has hung
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   // Mostly back to back, some short gaps, the odd long one
   function automatic int pick_gap(input bit calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: random stalls, plus a long hold-off when a test asks for one
   initial begin : rsp_ready_driver
      int gap;
      @(posedge clock);
      forever begin
         if (hold_off_request > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_request) @(posedge clock);
            hold_off_request = 0;
         end else begin
            gap = pick_gap(receiver_calm);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // One body byte; body_start is taken from mark_start
   task automatic send_byte(input logic [7:0] value);
      int gap;
      bit start;
      gap = pick_gap(sender_calm);
      start = mark_start;
      mark_start = 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{body_byte: value, body_start: start};
      offering = 1'b1;
      do @(posedge clock); while (!req_ready);
      decode_body_byte(value, start);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic release_sender();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // Always waits on the clock before the first check so the released valid settles first
   task automatic wait_drained();
      do @(posedge clock); while (decoded_due.size() != 0);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 10) return CHAR_ZERO + 8'(n);
      return (upper ? CHAR_UP_A : CHAR_LO_A) + 8'(n - 10);
   endfunction

   // Size line with random blanks, prefix, digit case and extension
   task automatic send_size_line(input int size);
      bit upper;
      bit leading;
      logic [3:0] digit;
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(0, 2))
            0: send_byte(CHAR_SPACE);
            1: send_byte(CHAR_TAB);
            default: send_byte(CHAR_CR - 8'd2);
         endcase
      end
      case ($urandom_range(0, 3))
         0: send_text("0x");
         1: send_text("0X");
         2: send_text("0");
         default: ;
      endcase
      upper = $urandom_range(0, 1);
      leading = 1'b1;
      for (int nib = 7; nib >= 0; nib--) begin
         digit = size[nib*4 +: 4];
         if (digit != 0 || nib == 0) leading = 1'b0;
         if (!leading) send_byte(hex_char(digit, upper));
      end
      case ($urandom_range(0, 5))
         0: send_text(";name=val");
         1: send_text(" \r x");
         default: ;
      endcase
      send_text("\r\n");
   endtask

   // Mostly well-formed body; sometimes cut short or with odd trailers
   task automatic send_random_body();
      int chunks;
      int size;
      mark_start = 1'b1;
      chunks = $urandom_range(0, 4);
      for (int k = 0; k < chunks; k++) begin
         size = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 200)
                                             : $urandom_range(1, 16);
         send_size_line(size);
         if ($urandom_range(0, 24) == 0) begin
            repeat ($urandom_range(0, size - 1)) send_byte(8'($urandom));
            return;
         end
         repeat (size) send_byte(8'($urandom));
         if ($urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom));
            send_byte(8'($urandom));
         end else begin
            send_text("\r\n");
         end
      end
      case ($urandom_range(0, 6))
         0: send_text("0;last\r\n");
         1: send_text(" \t0x0\r\n");
         2: send_text("\r\n");
         3: send_text("-5\r\n");
         4: send_text("0X\r\n");
         5: send_text("00\r\r\n");
         default: send_text("0\r\n");
      endcase
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
   endtask

   // Raw bytes with body_start at random
   task automatic send_noise();
      repeat ($urandom_range(1, 8)) begin
         mark_start = ($urandom_range(0, 3) == 0);
         send_byte(8'($urandom));
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Leading blank, 0X prefix, extreme data bytes, sign as size, bytes after end
   task automatic test_size_line_forms();
      mark_start = 1'b1;
      send_text(" 0X2\r\n");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("\r\n-\r\nZ");
      release_sender();
      wait_drained();
   endtask

   // CR not followed by LF inside the size line, then an empty size line
   task automatic test_lone_cr_and_empty_line();
      mark_start = 1'b1;
      send_text("1\r\r\n");
      send_byte(8'h80);
      send_text("\r\n\r\n");
      release_sender();
      wait_drained();
   endtask

   // Size past the counter maximum saturates; chunk cut short by a new body
   task automatic test_size_saturation();
      mark_start = 1'b1;
      send_text("fFfFfFfFf\r\n");
      send_byte(8'h5A);
      send_byte(8'hA5);
      release_sender();
      wait_drained();
   endtask

   // Receiver holds off for a long stretch while a full chunk is offered
   task automatic test_output_stall();
      sender_calm = 1'b1;
      hold_off_request = HOLD_OFF_CYCLES;
      mark_start = 1'b1;
      send_text("40\r\n");
      repeat (64) send_byte(8'($urandom));
      send_text("\r\n0\r\n");
      release_sender();
      wait_drained();
      sender_calm = 1'b0;
   endtask

   // Random bodies and noise; every tenth one the sender waits for the results
   task automatic test_random_bodies();
      int target;
      int bodies;
      target = items_sent + RANDOM_ITEMS;
      bodies = 0;
      while (items_sent < target) begin
         sender_calm = ($urandom_range(0, 7) == 0);
         receiver_calm = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 99) < 15) send_noise();
         else send_random_body();
         bodies++;
         if (bodies % 10 == 0) begin
            release_sender();
            wait_drained();
         end
      end
      release_sender();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_size_line_forms();
      test_lone_cr_and_empty_line();
      test_size_saturation();
      test_output_stall();
      test_random_bodies();
      wait_drained();
      repeat (5) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
